// File: rtl/gbfs_pkg.sv
// Shared codes and types for the grid breadth-first-search step block.
package gbfs_pkg;

	// Width of the row_bits load field.
	localparam int ROW_BITS_W = 16;

	// Item kinds.
	localparam logic KIND_LOAD  = 1'b0;
	localparam logic KIND_QUERY = 1'b1;

	// Move codes, also stored as the parent move of each reached cell.
	localparam logic [2:0] DIR_UP    = 3'd0;
	localparam logic [2:0] DIR_RIGHT = 3'd1;
	localparam logic [2:0] DIR_DOWN  = 3'd2;
	localparam logic [2:0] DIR_LEFT  = 3'd3;
	localparam logic [2:0] DIR_NONE  = 3'd4;

	// Neighbor visiting order.
	localparam logic [1:0] NB_LEFT  = 2'd0;
	localparam logic [1:0] NB_RIGHT = 2'd1;
	localparam logic [1:0] NB_UP    = 2'd2;
	localparam logic [1:0] NB_DOWN  = 2'd3;

	typedef enum logic [9:0] {
		ST_IDLE  = 10'b00_0000_0001,
		ST_CLEAR = 10'b00_0000_0010,
		ST_SEED  = 10'b00_0000_0100,
		ST_POP   = 10'b00_0000_1000,
		ST_POPW  = 10'b00_0001_0000,
		ST_NREAD = 10'b00_0010_0000,
		ST_NCHK  = 10'b00_0100_0000,
		ST_TVIS  = 10'b00_1000_0000,
		ST_TCHK  = 10'b01_0000_0000,
		ST_TRACE = 10'b10_0000_0000
	} state_t;

endpackage

// File: rtl/grid_bfs_next_step.sv
// Top level: walkable-grid map store and breadth-first first-move search.
//
// Usage: one command channel. A transaction is taken at a rising edge with start
// high and busy low. kind selects the item: a load writes row_bits into map row
// row_index (rows at or beyond ROWS are dropped) and completes in that same edge
// with no result; a query (from_x, from_y) -> (to_x, to_y) produces exactly one
// result, direction, shown for one cycle with done high. The receiver cannot
// stall: done is a single-cycle pulse and the result must be captured then.
// Steps of a query:
//   off-grid start or target : done from idle, busy never rises.
//   otherwise                : visited-flag clear of 2^(clog2(COLS)+clog2(ROWS))
//                              cells (128 for 16x8), a seed step, then for each
//                              reached cell a dequeue plus four neighbor probes
//                              on the map and visited read ports, a final pop,
//                              then the target check and the trace back.
// The probe loop on the single visited/map read port dominates how long a query
// keeps busy high. Busy is high the whole time and the next transaction is taken
// in the cycle done shows.
// Reset invalidates all map rows (all blocked) and returns the sequencer to idle.
module grid_bfs_next_step #(
	parameter int COLS = 16,
	parameter int ROWS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        kind,
	input  logic [2:0]  row_index,
	input  logic [15:0] row_bits,
	input  logic [3:0]  from_x,
	input  logic [2:0]  from_y,
	input  logic [3:0]  to_x,
	input  logic [2:0]  to_y,
	output logic        done,
	output logic [2:0]  direction
);

	localparam int XW = $clog2(COLS);
	localparam int YW = $clog2(ROWS);
	localparam int AW = XW + YW;
	localparam int QD = 1 << AW;
	localparam logic [XW:0] COLS_V = (XW + 1)'(COLS);
	localparam logic [YW:0] ROWS_V = (YW + 1)'(ROWS);

	gbfs_pkg::state_t state_q;

	// Control.
	logic [AW-1:0] clr_q;
	logic [AW:0]   head_q;
	logic [AW:0]   tail_q;
	logic [1:0]    k_q;
	logic          rowok_q;
	logic          done_q;
	logic [ROWS-1:0] map_vld_q;

	// Payload.
	logic [XW-1:0] sx_q, tx_q, cur_x_q;
	logic [YW-1:0] sy_q, ty_q, cur_y_q;
	logic [2:0]    last_mv_q;
	logic [2:0]    direction_q;

	// Transaction decode.
	logic take, take_load, take_query, row_ok, coords_ok;
	logic [COLS-1:0] load_row;

	assign take       = start && !busy;
	assign take_load  = take && (kind == gbfs_pkg::KIND_LOAD);
	assign take_query = take && (kind == gbfs_pkg::KIND_QUERY);
	assign row_ok     = {4'b0000, row_index} < 7'(ROWS);
	assign coords_ok  = ({3'b000, from_x} < 7'(COLS)) && ({4'b0000, from_y} < 7'(ROWS))
		&& ({3'b000, to_x} < 7'(COLS)) && ({4'b0000, to_y} < 7'(ROWS));

	// Columns past the load field width are never loaded and stay blocked.
	for (genvar i = 0; i < COLS; i++) begin : g_row
		if (i < gbfs_pkg::ROW_BITS_W) begin : g_in
			assign load_row[i] = row_bits[i];
		end else begin : g_zero
			assign load_row[i] = 1'b0;
		end
	end

	// Neighbor under probe: left, right, up, down of the current cell.
	logic [XW-1:0] nb_x;
	logic [YW-1:0] nb_y;
	logic          nb_in;
	logic [2:0]    nb_move;
	logic [AW-1:0] nb_addr;

	always_comb begin
		nb_x    = cur_x_q;
		nb_y    = cur_y_q;
		nb_in   = 1'b0;
		nb_move = gbfs_pkg::DIR_NONE;
		case (k_q)
			gbfs_pkg::NB_LEFT: begin
				nb_x    = cur_x_q - XW'(1);
				nb_in   = (cur_x_q != '0);
				nb_move = gbfs_pkg::DIR_LEFT;
			end
			gbfs_pkg::NB_RIGHT: begin
				nb_x    = cur_x_q + XW'(1);
				nb_in   = ({1'b0, cur_x_q} + (XW + 1)'(1)) < COLS_V;
				nb_move = gbfs_pkg::DIR_RIGHT;
			end
			gbfs_pkg::NB_UP: begin
				nb_y    = cur_y_q - YW'(1);
				nb_in   = (cur_y_q != '0);
				nb_move = gbfs_pkg::DIR_UP;
			end
			gbfs_pkg::NB_DOWN: begin
				nb_y    = cur_y_q + YW'(1);
				nb_in   = ({1'b0, cur_y_q} + (YW + 1)'(1)) < ROWS_V;
				nb_move = gbfs_pkg::DIR_DOWN;
			end
			default: begin
				nb_in = 1'b0;
			end
		endcase
	end

	assign nb_addr = {nb_y, nb_x};

	// Memories.
	logic          vis_we, vis_wdata, vis_rd;
	logic [AW-1:0] vis_waddr, vis_raddr;
	logic          par_we;
	logic [2:0]    par_wdata, par_rd;
	logic [AW-1:0] par_waddr, par_raddr;
	logic          que_we;
	logic [AW-1:0] que_waddr, que_wdata, que_rd;
	logic [COLS-1:0] row_rd;

	// Step back one cell along the parent move read for the current cell.
	logic [XW-1:0] prev_x;
	logic [YW-1:0] prev_y;

	always_comb begin
		prev_x = cur_x_q;
		prev_y = cur_y_q;
		case (par_rd)
			gbfs_pkg::DIR_UP:    prev_y = cur_y_q + YW'(1);
			gbfs_pkg::DIR_RIGHT: prev_x = cur_x_q - XW'(1);
			gbfs_pkg::DIR_DOWN:  prev_y = cur_y_q - YW'(1);
			gbfs_pkg::DIR_LEFT:  prev_x = cur_x_q + XW'(1);
			default: begin
				prev_x = cur_x_q;
			end
		endcase
	end

	// A neighbor joins the search when it is on the grid, walkable and unseen.
	logic nb_take;
	assign nb_take = (state_q == gbfs_pkg::ST_NCHK) && rowok_q && row_rd[nb_x] && !vis_rd;

	always_comb begin
		vis_we    = 1'b0;
		vis_waddr = nb_addr;
		vis_wdata = 1'b1;
		vis_raddr = nb_addr;
		par_we    = 1'b0;
		par_waddr = nb_addr;
		par_wdata = nb_move;
		par_raddr = {prev_y, prev_x};
		que_we    = 1'b0;
		que_waddr = tail_q[AW-1:0];
		que_wdata = nb_addr;
		case (state_q)
			gbfs_pkg::ST_CLEAR: begin
				vis_we    = 1'b1;
				vis_waddr = clr_q;
				vis_wdata = 1'b0;
			end
			gbfs_pkg::ST_SEED: begin
				// Start is always visited, even when blocked; it heads the queue.
				vis_we    = 1'b1;
				vis_waddr = {sy_q, sx_q};
				par_we    = 1'b1;
				par_waddr = {sy_q, sx_q};
				par_wdata = gbfs_pkg::DIR_NONE;
				que_we    = 1'b1;
				que_waddr = '0;
				que_wdata = {sy_q, sx_q};
			end
			gbfs_pkg::ST_NCHK: begin
				vis_we = nb_take;
				par_we = nb_take;
				que_we = nb_take;
			end
			gbfs_pkg::ST_TVIS: begin
				vis_raddr = {ty_q, tx_q};
				par_raddr = {ty_q, tx_q};
			end
			default: begin
				vis_we = 1'b0;
			end
		endcase
	end

	gbfs_ram #(.WIDTH(COLS), .DEPTH(ROWS)) u_walk (
		.clk   (clk),
		.we    (take_load && row_ok),
		.waddr (YW'(row_index)),
		.wdata (load_row),
		.raddr (nb_y),
		.rdata (row_rd)
	);

	gbfs_ram #(.WIDTH(1), .DEPTH(QD)) u_visited (
		.clk   (clk),
		.we    (vis_we),
		.waddr (vis_waddr),
		.wdata (vis_wdata),
		.raddr (vis_raddr),
		.rdata (vis_rd)
	);

	gbfs_ram #(.WIDTH(3), .DEPTH(QD)) u_parent (
		.clk   (clk),
		.we    (par_we),
		.waddr (par_waddr),
		.wdata (par_wdata),
		.raddr (par_raddr),
		.rdata (par_rd)
	);

	gbfs_ram #(.WIDTH(AW), .DEPTH(QD)) u_queue (
		.clk   (clk),
		.we    (que_we),
		.waddr (que_waddr),
		.wdata (que_wdata),
		.raddr (head_q[AW-1:0]),
		.rdata (que_rd)
	);

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= gbfs_pkg::ST_IDLE;
			clr_q     <= '0;
			head_q    <= '0;
			tail_q    <= '0;
			k_q       <= gbfs_pkg::NB_LEFT;
			rowok_q   <= 1'b0;
			done_q    <= 1'b0;
			map_vld_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (take_load && row_ok) begin
				map_vld_q[YW'(row_index)] <= 1'b1;
			end
			case (state_q)
				gbfs_pkg::ST_IDLE: begin
					if (take_query) begin
						if (coords_ok) begin
							clr_q   <= '0;
							state_q <= gbfs_pkg::ST_CLEAR;
						end else begin
							done_q <= 1'b1;
						end
					end
				end
				gbfs_pkg::ST_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == '1) begin
						state_q <= gbfs_pkg::ST_SEED;
					end
				end
				gbfs_pkg::ST_SEED: begin
					head_q  <= '0;
					tail_q  <= (AW + 1)'(1);
					state_q <= gbfs_pkg::ST_POP;
				end
				gbfs_pkg::ST_POP: begin
					if (head_q == tail_q) begin
						state_q <= gbfs_pkg::ST_TVIS;
					end else begin
						head_q  <= head_q + (AW + 1)'(1);
						state_q <= gbfs_pkg::ST_POPW;
					end
				end
				gbfs_pkg::ST_POPW: begin
					k_q     <= gbfs_pkg::NB_LEFT;
					state_q <= gbfs_pkg::ST_NREAD;
				end
				gbfs_pkg::ST_NREAD: begin
					rowok_q <= nb_in && map_vld_q[nb_y];
					state_q <= gbfs_pkg::ST_NCHK;
				end
				gbfs_pkg::ST_NCHK: begin
					if (nb_take) begin
						tail_q <= tail_q + (AW + 1)'(1);
					end
					if (k_q == gbfs_pkg::NB_DOWN) begin
						state_q <= gbfs_pkg::ST_POP;
					end else begin
						k_q     <= k_q + 2'd1;
						state_q <= gbfs_pkg::ST_NREAD;
					end
				end
				gbfs_pkg::ST_TVIS: begin
					state_q <= gbfs_pkg::ST_TCHK;
				end
				gbfs_pkg::ST_TCHK: begin
					// Unreached target, or target at the start: no move.
					if (!vis_rd || par_rd[2]) begin
						done_q  <= 1'b1;
						state_q <= gbfs_pkg::ST_IDLE;
					end else begin
						state_q <= gbfs_pkg::ST_TRACE;
					end
				end
				gbfs_pkg::ST_TRACE: begin
					if (par_rd[2]) begin
						done_q  <= 1'b1;
						state_q <= gbfs_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= gbfs_pkg::ST_IDLE;
				end
			endcase
		end
	end

	// Coordinates, trace state and result value.
	always_ff @(posedge clk) begin
		case (state_q)
			gbfs_pkg::ST_IDLE: begin
				sx_q        <= XW'(from_x);
				sy_q        <= YW'(from_y);
				tx_q        <= XW'(to_x);
				ty_q        <= YW'(to_y);
				direction_q <= gbfs_pkg::DIR_NONE;
			end
			gbfs_pkg::ST_POPW: begin
				cur_x_q <= que_rd[XW-1:0];
				cur_y_q <= que_rd[AW-1:XW];
			end
			gbfs_pkg::ST_TVIS: begin
				cur_x_q <= tx_q;
				cur_y_q <= ty_q;
			end
			gbfs_pkg::ST_TCHK: begin
				direction_q <= gbfs_pkg::DIR_NONE;
				last_mv_q   <= par_rd;
				cur_x_q     <= prev_x;
				cur_y_q     <= prev_y;
			end
			gbfs_pkg::ST_TRACE: begin
				// When this cell is the start, the move held is the first one.
				direction_q <= last_mv_q;
				last_mv_q   <= par_rd;
				cur_x_q     <= prev_x;
				cur_y_q     <= prev_y;
			end
			default: begin
				last_mv_q <= last_mv_q;
			end
		endcase
	end

	assign busy      = (state_q != gbfs_pkg::ST_IDLE);
	assign done      = done_q;
	assign direction = direction_q;

endmodule

// File: rtl/gbfs_ram.sv
// Generic single-write, single-read RAM with registered read data.
module gbfs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
